>>> rtl/closest_pair_1d_core_defines.svh
// Assertion macros for the closest pair core.
`ifndef CLOSEST_PAIR_1D_CORE_DEFINES_SVH
`define CLOSEST_PAIR_1D_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CP1D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define CP1D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/cp1d_pkg.sv
// Package for the closest pair core: sizes, payload types, states.
`timescale 1ns / 1ps
package cp1d_pkg;

  localparam int MAX_POINTS = 128;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int COORD_W    = 16;

  typedef struct packed {
    logic [COORD_W-1:0] point_value;
    logic               last_point;
  } in_t;

  typedef struct packed {
    logic               pair_found;
    logic [COORD_W-1:0] min_distance;
    logic [COORD_W-1:0] upper_point;
    logic [COORD_W-1:0] lower_point;
    logic               overflowed;
  } out_t;

  // Outputs of the shared subtract/compare unit.
  typedef struct packed {
    logic               borrow;  // op_a < op_b
    logic [COORD_W-1:0] diff;    // op_a - op_b, low bits
    logic               less;    // diff < best
  } gap_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_CMP,
    ST_INS_PUT,
    ST_SCAN_START,
    ST_SCAN_FIRST,
    ST_SCAN_RUN,
    ST_REPORT
  } state_t;

endpackage

>>> rtl/cp1d_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module cp1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cp1d_gap_unit.sv
// Shared subtract/compare unit: insertion order test and gap search.
`timescale 1ns / 1ps
module cp1d_gap_unit (
  input  logic [cp1d_pkg::COORD_W-1:0] op_a,
  input  logic [cp1d_pkg::COORD_W-1:0] op_b,
  input  logic [cp1d_pkg::COORD_W-1:0] best,
  output cp1d_pkg::gap_res_t           res
);

  logic [cp1d_pkg::COORD_W:0] sub;

  assign sub        = {1'b0, op_a} - {1'b0, op_b};
  assign res.borrow = sub[cp1d_pkg::COORD_W];
  assign res.diff   = sub[cp1d_pkg::COORD_W-1:0];
  assign res.less   = sub[cp1d_pkg::COORD_W-1:0] < best;

endmodule

>>> rtl/closest_pair_1d_core.sv
// Closest pair on a line: insertion into a sorted store, then an adjacent-gap scan.
// A point is written straight into an empty store or dropped by a full one, else inserted by a walk;
// the insertion walk reads one store entry per cycle through the shared compare unit.
// A marked point then starts a scan of adjacent gaps (skipped below two points); done pulses once.
// Results cannot be stalled. Reset clears the point count and the overflow flag;
// store contents stay undefined and are only read below the count.
`timescale 1ns / 1ps
`include "closest_pair_1d_core_defines.svh"
module closest_pair_1d_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  cp1d_pkg::in_t    point,
  output logic             done,
  output cp1d_pkg::out_t   result
);

  localparam int AW = cp1d_pkg::ADDR_W;
  localparam int CW = cp1d_pkg::CNT_W;
  localparam int DW = cp1d_pkg::COORD_W;

  cp1d_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic [AW-1:0] idx, idx_next;
  logic          ovf, ovf_next;
  logic          last, last_next;
  logic [DW-1:0] val, val_next;
  logic [DW-1:0] prev, prev_next;
  logic [DW-1:0] best, best_next;
  logic [DW-1:0] up, up_next;
  logic [DW-1:0] lo, lo_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [DW-1:0] wdata, rdata;
  logic [DW-1:0] op_a, op_b;
  cp1d_pkg::gap_res_t gap;
  logic          found;

  cp1d_ram #(.WIDTH(DW), .DEPTH(cp1d_pkg::MAX_POINTS)) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // insertion: val - store entry (borrow means entry is larger); scan: cur - prev
  assign op_a = (state == cp1d_pkg::ST_SCAN_RUN) ? rdata : val;
  assign op_b = (state == cp1d_pkg::ST_SCAN_RUN) ? prev : rdata;

  cp1d_gap_unit u_gap (
    .op_a (op_a),
    .op_b (op_b),
    .best (best),
    .res  (gap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cp1d_pkg::ST_IDLE;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    idx  <= idx_next;
    last <= last_next;
    val  <= val_next;
    prev <= prev_next;
    best <= best_next;
    up   <= up_next;
    lo   <= lo_next;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    pos_next   = pos;
    idx_next   = idx;
    ovf_next   = ovf;
    last_next  = last;
    val_next   = val;
    prev_next  = prev;
    best_next  = best;
    up_next    = up;
    lo_next    = lo;
    we         = 1'b0;
    waddr      = pos[AW-1:0];
    wdata      = val;
    raddr      = '0;
    busy       = 1'b1;
    done       = 1'b0;

    case (state)
      cp1d_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          val_next  = point.point_value;
          last_next = point.last_point;
          if (count >= CW'(cp1d_pkg::MAX_POINTS)) begin
            ovf_next = 1'b1;
            if (point.last_point) begin
              state_next = cp1d_pkg::ST_SCAN_START;
            end
          end else if (count == '0) begin
            we         = 1'b1;
            waddr      = '0;
            wdata      = point.point_value;
            count_next = CW'(1);
            if (point.last_point) begin
              state_next = cp1d_pkg::ST_SCAN_START;
            end
          end else begin
            pos_next   = count;
            raddr      = AW'(count - CW'(1));
            state_next = cp1d_pkg::ST_INS_CMP;
          end
        end
      end

      // rdata holds entry pos-1
      cp1d_pkg::ST_INS_CMP: begin
        if (gap.borrow) begin
          we       = 1'b1;
          wdata    = rdata;
          pos_next = pos - CW'(1);
          if (pos == CW'(1)) begin
            state_next = cp1d_pkg::ST_INS_PUT;
          end else begin
            raddr = AW'(pos - CW'(2));
          end
        end else begin
          we         = 1'b1;
          count_next = count + CW'(1);
          state_next = last ? cp1d_pkg::ST_SCAN_START : cp1d_pkg::ST_IDLE;
        end
      end

      cp1d_pkg::ST_INS_PUT: begin
        we         = 1'b1;
        count_next = count + CW'(1);
        state_next = last ? cp1d_pkg::ST_SCAN_START : cp1d_pkg::ST_IDLE;
      end

      cp1d_pkg::ST_SCAN_START: begin
        if (count < CW'(2)) begin
          state_next = cp1d_pkg::ST_REPORT;
        end else begin
          raddr      = '0;
          state_next = cp1d_pkg::ST_SCAN_FIRST;
        end
      end

      cp1d_pkg::ST_SCAN_FIRST: begin
        prev_next  = rdata;
        raddr      = AW'(1);
        idx_next   = AW'(1);
        state_next = cp1d_pkg::ST_SCAN_RUN;
      end

      // rdata holds entry idx; strict compare keeps the lowest pair on ties
      cp1d_pkg::ST_SCAN_RUN: begin
        prev_next = rdata;
        if (idx == AW'(1) || gap.less) begin
          best_next = gap.diff;
          lo_next   = prev;
          up_next   = rdata;
        end
        if (CW'(idx) == count - CW'(1)) begin
          state_next = cp1d_pkg::ST_REPORT;
        end else begin
          raddr    = idx + AW'(1);
          idx_next = idx + AW'(1);
        end
      end

      cp1d_pkg::ST_REPORT: begin
        done       = 1'b1;
        count_next = '0;
        ovf_next   = 1'b0;
        state_next = cp1d_pkg::ST_IDLE;
      end

      default: begin
        state_next = cp1d_pkg::ST_IDLE;
      end
    endcase
  end

  assign found               = count >= CW'(2);
  assign result.pair_found   = found;
  assign result.min_distance = found ? best : '0;
  assign result.upper_point  = found ? up : '0;
  assign result.lower_point  = found ? lo : '0;
  assign result.overflowed   = ovf;

  `CP1D_ASSERT_NEXT(a_clear_after_beat, done, (count == '0) && !ovf, "set not cleared after result")
  `CP1D_ASSERT_NOW(a_count_bound, 1'b1, count <= CW'(cp1d_pkg::MAX_POINTS), "point count beyond capacity")
  `CP1D_ASSERT_NOW(a_scan_sorted, state == cp1d_pkg::ST_SCAN_RUN, !gap.borrow, "store not in ascending order")
  `CP1D_ASSERT_NOW(a_gap_match, done && result.pair_found, result.upper_point - result.lower_point == result.min_distance, "reported gap does not match pair")

endmodule

>>> tb/closest_pair_checker.sv
// Checker for the closest pair core: watches point and result beats, predicts, compares.
`timescale 1ns / 1ps
module closest_pair_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           busy,
  input  cp1d_pkg::in_t  point,
  input  logic           done,
  input  cp1d_pkg::out_t result,
  output int             fail_count,
  output int             pending
);
  import cp1d_pkg::*;

  logic [COORD_W-1:0] sorted_pts [MAX_POINTS];
  int unsigned        pt_count;
  bit                 dropped;
  out_t               expected_pairs [$];

  // Insertion keeps equal coordinates below the newcomer.
  function automatic void insert_sorted(input logic [COORD_W-1:0] v);
    int unsigned pos;
    if (pt_count >= MAX_POINTS) begin
      dropped = 1'b1;
      return;
    end
    pos = pt_count;
    while (pos > 0 && sorted_pts[pos-1] > v) begin
      sorted_pts[pos] = sorted_pts[pos-1];
      pos--;
    end
    sorted_pts[pos] = v;
    pt_count++;
  endfunction

  // Strict less-than keeps the lowest pair on equal gaps.
  function automatic out_t closest_of_set();
    out_t               r;
    logic [COORD_W-1:0] g;
    r = '0;
    if (pt_count >= 2) begin
      r.pair_found   = 1'b1;
      r.lower_point  = sorted_pts[0];
      r.upper_point  = sorted_pts[1];
      r.min_distance = sorted_pts[1] - sorted_pts[0];
      for (int i = 2; i < pt_count; i++) begin
        g = sorted_pts[i] - sorted_pts[i-1];
        if (g < r.min_distance) begin
          r.min_distance = g;
          r.lower_point  = sorted_pts[i-1];
          r.upper_point  = sorted_pts[i];
        end
      end
    end
    r.overflowed = dropped;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [COORD_W-1:0] exp_v,
                                      input logic [COORD_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d (0x%h), got %0d (0x%h)",
               $time, name, exp_v, exp_v, act_v, act_v);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t exp_r;
    if (rst) begin
      pt_count   = 0;
      dropped    = 1'b0;
      fail_count = 0;
    end else begin
      // result beat first: it always belongs to an earlier set
      if (done === 1'b1) begin
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected result: expected none, got %h", $time, result);
          fail_count++;
        end else begin
          exp_r = expected_pairs.pop_front();
          check_field("pair_found", exp_r.pair_found, result.pair_found);
          check_field("min_distance", exp_r.min_distance, result.min_distance);
          check_field("upper_point", exp_r.upper_point, result.upper_point);
          check_field("lower_point", exp_r.lower_point, result.lower_point);
          check_field("overflowed", exp_r.overflowed, result.overflowed);
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        insert_sorted(point.point_value);
        if (point.last_point) begin
          expected_pairs.push_back(closest_of_set());
          pt_count = 0;
          dropped  = 1'b0;
        end
      end
    end
    pending = expected_pairs.size();
  end

endmodule

>>> tb/tb_top.sv
// Top of the closest pair testbench: clock, reset, point stimulus, watchdog, verdict.
`timescale 1ns / 1ps
module tb_top;
  import cp1d_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int RANDOM_ITEMS = 160;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  in_t  point = '0;
  logic done;
  out_t result;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   random_sent = 0;

  always #6 clk = ~clk;

  closest_pair_1d_core uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .point  (point),
    .done   (done),
    .result (result)
  );

  closest_pair_checker pair_chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .point      (point),
    .done       (done),
    .result     (result),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Watchdog: cycles with neither a point beat nor a result beat.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Mostly back to back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(15, 80);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_point(input logic [COORD_W-1:0] v, input logic last, input bit burst);
    int gap;
    gap = burst ? 0 : pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) begin
        point = in_t'($urandom);
        @(negedge clk);
      end
    end
    start = 1'b1;
    point.point_value = v;
    point.last_point  = last;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // 0: anywhere, 1: tight cluster, 2: coarse grid with repeats and equal gaps
  function automatic logic [COORD_W-1:0] make_coord(input int mode, input logic [COORD_W-1:0] base);
    case (mode)
      0: return COORD_W'($urandom);
      1: return COORD_W'(base + $urandom_range(0, 31));
      default: return COORD_W'(base + 5 * $urandom_range(0, 6));
    endcase
  endfunction

  task automatic send_random_set(input int size);
    int                 mode;
    bit                 burst;
    logic [COORD_W-1:0] base;
    mode  = $urandom_range(0, 2);
    base  = COORD_W'($urandom);
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < size; i++) begin
      send_point(make_coord(mode, base), (i == size - 1), burst);
      random_sent++;
    end
  endtask

  initial begin
    int r;
    int size;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    // single point, no pair
    send_point(16'd1234, 1'b1, 1'b0);
    // extremes
    send_point(16'd0, 1'b0, 1'b0);
    send_point(16'hFFFF, 1'b1, 1'b0);
    // equal coordinates
    send_point(16'd500, 1'b0, 1'b0);
    send_point(16'd500, 1'b1, 1'b0);
    // equal gaps, unsorted arrival: lowest pair wins
    send_point(16'd300, 1'b0, 1'b0);
    send_point(16'd100, 1'b0, 1'b0);
    send_point(16'd200, 1'b0, 1'b0);
    send_point(16'd400, 1'b1, 1'b0);
    // tie between top and bottom of the range
    send_point(16'hFFFF, 1'b0, 1'b1);
    send_point(16'hFFFE, 1'b0, 1'b1);
    send_point(16'd0, 1'b0, 1'b1);
    send_point(16'd1, 1'b1, 1'b1);
    // repeats mixed in
    send_point(16'd7, 1'b0, 1'b0);
    send_point(16'd9, 1'b0, 1'b0);
    send_point(16'd7, 1'b0, 1'b0);
    send_point(16'd3, 1'b0, 1'b0);
    send_point(16'd9, 1'b1, 1'b0);
    // lone zero, then three equal points
    send_point(16'd0, 1'b1, 1'b0);
    send_point(16'd42, 1'b0, 1'b1);
    send_point(16'd42, 1'b0, 1'b1);
    send_point(16'd42, 1'b1, 1'b1);

    // small sets make up most of the random sets
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 10) size = 1;
      else if (r < 80) size = $urandom_range(2, 8);
      else size = $urandom_range(9, 40);
      send_random_set(size);
    end

    // exactly full, then an overflow that drops a plain point and the marked one
    send_random_set(MAX_POINTS);
    send_random_set(MAX_POINTS + 2);
    for (int i = 0; i < 4; i++) send_random_set($urandom_range(1, 6));

    start = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/cp1d_pkg.sv
rtl/cp1d_ram.sv
rtl/cp1d_gap_unit.sv
rtl/closest_pair_1d_core.sv
tb/closest_pair_checker.sv
tb/tb_top.sv
